[hw/rtl/oaht_pkg.sv]
`default_nettype none

package oaht_pkg;

    localparam int DEFAULT_SLOTS = 64;
    localparam int KEY_W         = 32;
    localparam int HASH_W        = 32;
    localparam int VAL_W         = 64;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 2;
    localparam int LIMIT_W       = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd48;

    localparam logic [ACT_W-1:0] ACT_GET = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DEL = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic             live;
        logic             tomb;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_REDUCE,
        ST_PROBE,
        ST_CHECK
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/open_addressed_hash_table.sv]
// With power-of-two SLOTS each slot probed takes PROBE and CHECK, and the result strobe
// is registered from the last CHECK; other slot counts first add MOD and REDUCE.
// Throughput: one transaction at a time; busy stays high until the result is strobed.
// Unknown action: result strobed the cycle after start, no probe.
// Reset: a clearing pass over the slot memory, busy high meanwhile.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module open_addressed_hash_table
    import oaht_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [ACT_W-1:0]   action,
    input  wire logic [KEY_W-1:0]   key_id,
    input  wire logic [HASH_W-1:0]  key_hash,
    input  wire logic [VAL_W-1:0]   value_in,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LIMIT_W-1:0] cfg_data,
    output logic                    done,
    output logic [STAT_W-1:0]       status,
    output logic                    new_key,
    output logic [VAL_W-1:0]        value_out
);

    localparam int  IDX_W   = $clog2(SLOTS);
    localparam int  CNT_W   = IDX_W + 1;
    localparam int  CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam bit  IS_POW2 = ((1 << IDX_W) == SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int  MOD_SH  = HASH_W + IDX_W;
    localparam logic [63:0] MAGIC_FULL = ((64'd1 << MOD_SH) + 64'(SLOTS - 1)) / 64'(SLOTS);
    localparam logic [HASH_W:0] MAGIC = (HASH_W + 1)'(MAGIC_FULL);
    localparam logic [IDX_W-1:0] SLOTS_LO = IDX_W'(SLOTS);

    state_t               state_reg, state_next;
    logic [ACT_W-1:0]     action_reg, action_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [HASH_W-1:0]    hash_reg, hash_next;
    logic [IDX_W-1:0]     quot_reg, quot_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     n_reg, n_next;
    logic                 tomb_seen_reg, tomb_seen_next;
    logic [IDX_W-1:0]     tomb_idx_reg, tomb_idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 done_reg, done_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic                 new_key_reg, new_key_next;
    logic [VAL_W-1:0]     vout_reg, vout_next;
    entry_t               rd_data_reg;

    entry_t               mem [SLOTS];

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic                 accept;
    logic                 act_valid;
    logic                 hit;
    logic                 pass;
    logic                 last;
    logic                 more;
    logic                 tomb_any;
    logic [IDX_W-1:0]     tomb_at;
    logic [IDX_W-1:0]     idx_wrap;
    logic [2*HASH_W:0]    mod_prod;
    logic                 room;

    assign accept    = start && (state_reg == ST_IDLE);
    assign act_valid = (action == ACT_GET) || (action == ACT_SET) || (action == ACT_DEL);
    assign hit       = rd_data_reg.live && (rd_data_reg.key == key_reg);
    assign pass      = (rd_data_reg.live || rd_data_reg.tomb) && !hit;
    assign last      = (n_reg == LAST_IDX);
    assign more      = pass && !last;
    assign tomb_any  = tomb_seen_reg || rd_data_reg.tomb;
    assign tomb_at   = tomb_seen_reg ? tomb_idx_reg : idx_reg;
    assign idx_wrap  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign mod_prod  = {{HASH_W{1'b0}}, MAGIC} * {{(HASH_W + 1){1'b0}}, hash_reg};
    assign room      = CMP_W'(count_reg) < CMP_W'(limit_reg);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign status    = status_reg;
    assign new_key   = new_key_reg;
    assign value_out = vout_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && act_valid)
                begin
                    state_next = IS_POW2 ? ST_PROBE : ST_MOD;
                end
            end
            ST_MOD:
            begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = more ? ST_PROBE : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        action_next    = action_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        hash_next      = hash_reg;
        quot_next      = quot_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        tomb_seen_next = tomb_seen_reg;
        tomb_idx_next  = tomb_idx_reg;
        count_next     = count_reg;
        clr_idx_next   = clr_idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        new_key_next   = 1'b0;
        vout_next      = '0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    action_next    = action;
                    key_next       = key_id;
                    val_next       = value_in;
                    hash_next      = key_hash;
                    idx_next       = IS_POW2 ? key_hash[IDX_W-1:0] : '0;
                    n_next         = '0;
                    tomb_seen_next = 1'b0;
                    if (!act_valid)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_MISS;
                    end
                end
            end
            ST_MOD:
            begin
                // reciprocal multiply, only the low quotient bits are kept
                quot_next = mod_prod[MOD_SH +: IDX_W];
            end
            ST_REDUCE:
            begin
                idx_next = hash_reg[IDX_W-1:0] - IDX_W'(quot_reg * SLOTS_LO);
            end
            ST_PROBE:
            begin
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_DONE;
                    if (action_reg == ACT_GET)
                    begin
                        vout_next = rd_data_reg.value;
                    end
                    else if (action_reg == ACT_SET)
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{live: 1'b1, tomb: 1'b0, key: key_reg, value: val_reg};
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{live: 1'b0, tomb: 1'b1, key: rd_data_reg.key,
                                    value: rd_data_reg.value};
                    end
                end
                else if (more)
                begin
                    if (rd_data_reg.tomb && !tomb_seen_reg)
                    begin
                        tomb_seen_next = 1'b1;
                        tomb_idx_next  = idx_reg;
                    end
                    idx_next = idx_wrap;
                    n_next   = n_reg + 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                    if (action_reg != ACT_SET)
                    begin
                        status_next = STAT_MISS;
                    end
                    else if (tomb_any)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = tomb_at;
                        wr_data      = '{live: 1'b1, tomb: 1'b0, key: key_reg, value: val_reg};
                        status_next  = STAT_DONE;
                        new_key_next = 1'b1;
                    end
                    else if (!pass && room)
                    begin
                        wr_en        = 1'b1;
                        wr_data      = '{live: 1'b1, tomb: 1'b0, key: key_reg, value: val_reg};
                        count_next   = count_reg + 1'b1;
                        status_next  = STAT_DONE;
                        new_key_next = 1'b1;
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            done_reg      <= 1'b0;
            tomb_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            tomb_seen_reg <= tomb_seen_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        hash_reg     <= hash_next;
        quot_reg     <= quot_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        tomb_idx_reg <= tomb_idx_next;
        status_reg   <= status_next;
        new_key_reg  <= new_key_next;
        vout_reg     <= vout_next;
    end

`ifndef SYNTHESIS
    a_new_key_done: assert property (@(posedge clk) disable iff (!rst_n)
        done && new_key |-> status == STAT_DONE)
        else $error("new_key without done status");

    a_vout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STAT_DONE |-> value_out == '0)
        else $error("value_out nonzero on failed transaction");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("occupied count moved by other than one");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && act_valid |=> busy && !done)
        else $error("valid transaction not held busy");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg != ST_IDLE)
        else $error("slot write while idle");
`endif

endmodule

`default_nettype wire

[verif/tb_open_addressed_hash_table.sv]
module tb_open_addressed_hash_table;
    import oaht_pkg::*;

    localparam int SLOTS         = DEFAULT_SLOTS;
    localparam int IDX_W         = $clog2(SLOTS);
    localparam int POOL          = 80;
    localparam int PHASE_ITEMS   = 306;
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 40;

    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              new_key;
        logic [VAL_W-1:0]  value;
    } reply_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic [ACT_W-1:0]   action    = '0;
    logic [KEY_W-1:0]   key_id    = '0;
    logic [HASH_W-1:0]  key_hash  = '0;
    logic [VAL_W-1:0]   value_in  = '0;
    logic               cfg_valid = 1'b0;
    logic [LIMIT_W-1:0] cfg_data  = '0;
    logic               busy;
    logic               cfg_ready;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic               new_key;
    logic [VAL_W-1:0]   value_out;

    open_addressed_hash_table #(.SLOTS(SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .key_id    (key_id),
        .key_hash  (key_hash),
        .value_in  (value_in),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .status    (status),
        .new_key   (new_key),
        .value_out (value_out)
    );

    always #5 clk = ~clk;

    // Shadow copy of the table
    logic [KEY_W-1:0] tbl_key   [SLOTS];
    logic [VAL_W-1:0] tbl_value [SLOTS];
    bit               tbl_live  [SLOTS];
    bit               tbl_tomb  [SLOTS];
    int               tbl_count = 0;
    int               tbl_limit = int'(LIMIT_RESET);

    reply_t           table_replies[$];

    logic [KEY_W-1:0]  pool_key  [POOL];
    logic [HASH_W-1:0] pool_hash [POOL];

    bit no_idle = 1'b0;
    int errors = 0;
    int cycles = 0;
    int n_get = 0;
    int n_set = 0;
    int n_del = 0;
    int n_other = 0;
    int n_hit = 0;
    int n_reuse = 0;
    int n_full = 0;
    int n_checked = 0;

    function automatic reply_t apply_table_op(input logic [ACT_W-1:0] act,
                                              input logic [KEY_W-1:0] key,
                                              input logic [HASH_W-1:0] hash,
                                              input logic [VAL_W-1:0] val);
        reply_t r;
        int     idx;
        int     hit_at;
        int     empty_at;
        int     tomb_at;
        bit     stopped;
        r.status  = STAT_MISS;
        r.new_key = 1'b0;
        r.value   = '0;
        hit_at    = -1;
        empty_at  = -1;
        tomb_at   = -1;
        stopped   = 1'b0;
        idx       = int'(hash % SLOTS);
        if (act != ACT_UNKNOWN)
        begin
            for (int n = 0; n < SLOTS && !stopped; n++)
            begin
                if (tbl_live[idx])
                begin
                    if (tbl_key[idx] == key)
                    begin
                        hit_at  = idx;
                        stopped = 1'b1;
                    end
                end
                else if (tbl_tomb[idx])
                begin
                    if (tomb_at < 0)
                        tomb_at = idx;
                end
                else
                begin
                    empty_at = idx;
                    stopped  = 1'b1;
                end
                idx = (idx + 1) % SLOTS;
            end
        end
        if (act == ACT_GET)
        begin
            n_get++;
            if (hit_at >= 0)
            begin
                r.status = STAT_DONE;
                r.value  = tbl_value[hit_at];
                n_hit++;
            end
        end
        else if (act == ACT_DEL)
        begin
            n_del++;
            if (hit_at >= 0)
            begin
                tbl_live[hit_at] = 1'b0;
                tbl_tomb[hit_at] = 1'b1;
                r.status = STAT_DONE;
            end
        end
        else if (act == ACT_SET)
        begin
            n_set++;
            if (hit_at >= 0)
            begin
                tbl_value[hit_at] = val;
                r.status = STAT_DONE;
            end
            else if (tomb_at >= 0)
            begin
                tbl_tomb[tomb_at]  = 1'b0;
                tbl_live[tomb_at]  = 1'b1;
                tbl_key[tomb_at]   = key;
                tbl_value[tomb_at] = val;
                r.status  = STAT_DONE;
                r.new_key = 1'b1;
                n_reuse++;
            end
            else if (empty_at >= 0 && tbl_count < tbl_limit)
            begin
                tbl_live[empty_at]  = 1'b1;
                tbl_key[empty_at]   = key;
                tbl_value[empty_at] = val;
                tbl_count++;
                r.status  = STAT_DONE;
                r.new_key = 1'b1;
            end
            else
            begin
                r.status = STAT_FULL;
                n_full++;
            end
        end
        else
        begin
            n_other++;
        end
        return r;
    endfunction

    // start is left high after acceptance; the caller either sends again in the
    // same step or lowers it through finish_outstanding
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                                input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] val);
        int gap;
        if ($urandom_range(0, 99) < 3)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        action   <= act;
        key_id   <= key;
        key_hash <= hash;
        value_in <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        table_replies.push_back(apply_table_op(act, key, hash, val));
    endtask

    task automatic finish_outstanding();
        start <= 1'b0;
        do
            @(posedge clk);
        while (table_replies.size() != 0);
    endtask

    task automatic write_load_limit(input logic [LIMIT_W-1:0] lim);
        finish_outstanding();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tbl_limit = int'(lim);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_request();
        int               r;
        int               pick;
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        logic [HASH_W-1:0] hash;
        r = $urandom_range(0, 99);
        if (r < 40)
            act = ACT_SET;
        else if (r < 72)
            act = ACT_GET;
        else if (r < 95)
            act = ACT_DEL;
        else
            act = ACT_UNKNOWN;
        pick = $urandom_range(0, POOL - 1);
        key  = pool_key[pick];
        hash = pool_hash[pick];
        r = $urandom_range(0, 99);
        if (r < 8)
            hash = $urandom;
        else if (r < 14)
        begin
            key  = $urandom;
            hash = $urandom;
        end
        send_request(act, key, hash, {$urandom, $urandom});
    endtask

    task automatic run_random_phase(input logic [LIMIT_W-1:0] lim, input int items,
                                    input bit pause_midway);
        write_load_limit(lim);
        for (int i = 0; i < items; i++)
        begin
            if (pause_midway && i == items / 2)
                finish_outstanding();
            random_request();
        end
    endtask

    task automatic test_basic_ops();
        send_request(ACT_GET, 32'h0, 32'h0, 64'h0);
        send_request(ACT_DEL, 32'h0, 32'h0, 64'h0);
        send_request(ACT_SET, 32'h0, 32'h0, 64'h0);
        send_request(ACT_SET, 32'h0, 32'h0, '1);
        send_request(ACT_GET, 32'h0, 32'h0, 64'h0);
        send_request(ACT_SET, '1, '1, 64'h5555_5555_5555_5555);
        // collides on the last slot and wraps to the front
        send_request(ACT_SET, 32'h1, 32'h0000_003F, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACT_GET, 32'h1, 32'h0000_003F, 64'h0);
        send_request(ACT_DEL, 32'h0, 32'h0, 64'h0);
        send_request(ACT_GET, 32'h1, 32'h0000_003F, 64'h0);
        send_request(ACT_SET, 32'h2, 32'h8000_003F, 64'h0123_4567_89AB_CDEF);
        send_request(ACT_GET, 32'h0, 32'h0, 64'h0);
        send_request(ACT_UNKNOWN, 32'h0, 32'h0, '1);
        send_request(ACT_DEL, 32'h1234_5678, 32'h0, 64'h0);
    endtask

    task automatic test_load_limit_and_tombstones();
        // limit zero: fresh inserts rejected, overwrite and tombstone reuse still work
        write_load_limit('0);
        send_request(ACT_SET, 32'h3, 32'd10, 64'h1);
        send_request(ACT_SET, '1, '1, 64'h0);
        send_request(ACT_DEL, 32'h1, 32'h0000_003F, 64'h0);
        send_request(ACT_SET, 32'h4, 32'h0000_003F, 64'h2);
        write_load_limit(6'd4);
        send_request(ACT_SET, 32'h3, 32'd10, 64'h3);
        send_request(ACT_SET, 32'h5, 32'd20, 64'h4);
        send_request(ACT_DEL, 32'h3, 32'd10, 64'h0);
        send_request(ACT_SET, 32'h5, 32'd10, 64'h5);
        send_request(ACT_GET, 32'h5, 32'd10, 64'h0);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < POOL; i++)
        begin
            pool_key[i]  = $urandom;
            pool_hash[i] = $urandom;
            case ($urandom_range(0, 2))
                0: pool_hash[i][IDX_W-1:0] = IDX_W'($urandom_range(0, 7));
                1: pool_hash[i][IDX_W-1:0] = IDX_W'(SLOTS - 4 + $urandom_range(0, 7));
                default: ;
            endcase
        end
        pool_key[0] = '0;
        pool_key[1] = '1;
        run_random_phase(LIMIT_W'($urandom_range(2, 16)), PHASE_ITEMS, 1'b0);
        run_random_phase(6'd32, PHASE_ITEMS, 1'b0);
        run_random_phase(6'd63, PHASE_ITEMS, 1'b1);
        run_random_phase(6'd1, PHASE_ITEMS, 1'b0);
        run_random_phase(LIMIT_W'($urandom_range(1, 63)), PHASE_ITEMS, 1'b0);
    endtask

    always @(posedge clk)
    begin : check_result
        reply_t want;
        if (done)
        begin
            if (table_replies.size() == 0)
            begin
                $display("%0t: unexpected transaction result, status %0d", $time, status);
                errors++;
            end
            else
            begin
                want = table_replies.pop_front();
                n_checked++;
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
                    errors++;
                end
                if (new_key !== want.new_key)
                begin
                    $display("%0t: new_key expected %0d, actual %0d",
                             $time, want.new_key, new_key);
                    errors++;
                end
                if (value_out !== want.value)
                begin
                    $display("%0t: value_out expected %h, actual %h",
                             $time, want.value, value_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_basic_ops();
        test_load_limit_and_tombstones();
        test_random_traffic();
        finish_outstanding();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d gets, %0d sets, %0d deletes, %0d unknown actions; %0d results checked",
                 n_get, n_set, n_del, n_other, n_checked);
        $display("%0d get hits, %0d tombstone reuses, %0d full rejections, load limits 0..63",
                 n_hit, n_reuse, n_full);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
